/* hdl/assert_macros.svh */
// Assertion macros shared by the checker files.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define COI_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("same-cycle check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define COI_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("next-cycle check failed");

`endif

/* hdl/coi_pkg.sv */
// Shared widths, constants, types and the node spacing table for the
// column omega integrator. No dependencies.
`default_nettype none

package coi_pkg;

	localparam int FixW      = 32;  // Q16.16 samples and omega
	localparam int SumW      = 33;  // sum of two samples
	localparam int SpcW      = 17;  // Q0.16 spacing, 1.0 included
	localparam int ProdW     = 51;  // signed sum times unsigned spacing
	localparam int IntW      = 52;  // running integral
	localparam int MagW      = 51;  // magnitude of the integral
	localparam int LvlW      = 3;   // level index
	localparam int CntW      = 4;   // level_count register
	localparam int DivSteps  = 33;  // quotient bits below the saturation limit
	localparam int DivCntW   = $clog2(DivSteps);

	localparam int MaxLevelsDefault = 8;
	localparam logic [CntW-1:0] LevelCountReset = 4'd3;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_MUL  = 6'b000010,
		S_ACC  = 6'b000100,
		S_PREP = 6'b001000,
		S_DIV  = 6'b010000,
		S_FIN  = 6'b100000
	} coi_state_t;

	typedef struct packed {
		logic load;   // input transfer
		logic mul;
		logic acc;
		logic prep;
		logic div;
		logic fin;    // load result register
	} coi_cmd_t;

	typedef struct packed {
		logic skip_div;  // bottom level or zero depth sum
		logic out_free;  // result register can take a new result
	} coi_sts_t;

	// Q0.16 spacing between levels k-1 and k for a column of n levels
	function automatic logic [SpcW-1:0] node_spacing(input logic [CntW-1:0] n,
			input logic [LvlW-1:0] k);
		logic [CntW-1:0] kc;
		logic [SpcW-1:0] s;
		kc = {1'b0, k};
		if (kc < 4'd1) kc = 4'd1;
		if (n >= 4'd2 && kc > n - 4'd1) kc = n - 4'd1;
		case (n)
			4'd2:    s = 17'd65536;
			4'd3:    s = 17'd32768;
			4'd4:    s = (kc == 4'd2) ? 17'd29308 : 17'd18114;
			4'd5:    s = (kc inside {4'd1, 4'd4}) ? 17'd11316 : 17'd21452;
			4'd6:    s = 17'd13107;
			4'd7:    s = 17'd10923;
			4'd8:    s = 17'd9362;
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

/* hdl/coi_if.sv */
// Valid/ready channel interfaces for the column omega integrator.
// Depends on coi_pkg.
`default_nettype none

interface coi_in_if import coi_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic signed [FixW-1:0] div_sample;
	logic        [FixW-1:0] depth_sample;
	logic signed [FixW-1:0] bed_omega;

	modport source (output valid, div_sample, depth_sample, bed_omega, input ready);
	modport sink   (input valid, div_sample, depth_sample, bed_omega, output ready);
endinterface

interface coi_out_if import coi_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic signed [FixW-1:0] omega;
	logic        [LvlW-1:0] level_index;
	logic                   column_end;
	logic                   thin_layer;

	modport source (output valid, omega, level_index, column_end, thin_layer, input ready);
	modport sink   (input valid, omega, level_index, column_end, thin_layer, output ready);
endinterface

`default_nettype wire

/* hdl/coi_ctrl.sv */
// Sequencer for one level: multiply, accumulate, divide, result load.
// Depends on coi_pkg.
`default_nettype none

module coi_ctrl import coi_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire coi_sts_t sts,
	output coi_cmd_t      cmd
);

	coi_state_t         state_q, state_d;
	logic [DivCntW-1:0] step_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = sts.skip_div ? S_FIN : S_PREP;
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_DIV;
			end
			S_DIV: begin
				cmd.div = 1'b1;
				if (step_q == DivCntW'(DivSteps - 1)) state_d = S_FIN;
			end
			S_FIN: begin
				cmd.fin = sts.out_free;
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.prep) step_q <= '0;
			else if (cmd.div) step_q <= step_q + DivCntW'(1);
		end
	end

endmodule

`default_nettype wire

/* hdl/coi_dp.sv */
// Datapath: column state, trapezoid term, restoring divider, saturation and
// the result register. Depends on coi_pkg.
`default_nettype none

module coi_dp import coi_pkg::*; #(
	parameter int MAX_LEVELS = MaxLevelsDefault
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_wr_en,
	input  wire logic        [CntW-1:0] cfg_wr_data,
	input  wire logic signed [FixW-1:0] div_sample,
	input  wire logic        [FixW-1:0] depth_sample,
	input  wire logic signed [FixW-1:0] bed_omega,
	input  wire coi_cmd_t               cmd,
	output coi_sts_t                    sts,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic signed [FixW-1:0]      omega,
	output logic        [LvlW-1:0]      level_index,
	output logic                        column_end,
	output logic                        thin_layer
);

	localparam int EffMax = (MAX_LEVELS < 8) ? MAX_LEVELS : 8;

	// column state
	logic        [CntW-1:0] level_count_q;
	logic        [LvlW-1:0] level_counter_q;
	logic signed [FixW-1:0] prev_div_q;
	logic        [FixW-1:0] prev_depth_q;
	logic signed [IntW-1:0] integral_q;
	logic signed [FixW-1:0] held_bottom_q;

	// per-item working registers
	logic signed [SumW-1:0]  dsum_q;
	logic        [SumW-1:0]  hsum_q;
	logic        [SpcW-1:0]  spacing_q;
	logic        [LvlW-1:0]  k_q;
	logic                    end_q;
	logic signed [ProdW-1:0] product_q;
	logic                    neg_q;
	logic                    big_q;
	logic        [SumW-1:0]  rem_q;
	logic        [SumW-1:0]  mag_lo_q;
	logic        [SumW-1:0]  quo_q;
	logic                    out_valid_q;

	logic [CntW-1:0] n_eff;
	logic            level_end;

	always_comb begin
		if (level_count_q == '0) n_eff = 4'd1;
		else if (int'(level_count_q) > EffMax) n_eff = CntW'(EffMax);
		else n_eff = level_count_q;
	end

	assign level_end = ({1'b0, level_counter_q} + 4'd1) >= n_eff;

	// magnitude and saturation test of the integral
	logic signed [IntW-1:0] int_neg;
	logic        [MagW-1:0] mag;
	logic                   big;

	assign int_neg = -integral_q;
	assign mag     = integral_q[IntW-1] ? int_neg[MagW-1:0] : integral_q[MagW-1:0];
	assign big     = {15'd0, mag} >= {hsum_q, 33'd0};

	// one restoring step
	logic [SumW:0] trial;
	logic          fits;

	assign trial = {rem_q, mag_lo_q[SumW-1]};
	assign fits  = trial >= {1'b0, hsum_q};

	// final omega
	logic        [SumW:0]   qmag;
	logic signed [SumW+1:0] qsig;
	logic signed [FixW+3:0] diff;
	logic signed [FixW-1:0] omega_d;
	logic                   thin_d;

	always_comb begin
		qmag    = big_q ? {1'b1, {SumW{1'b0}}} : {1'b0, quo_q};
		qsig    = neg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
		diff    = {{4{held_bottom_q[FixW-1]}}, held_bottom_q} - {qsig[SumW+1], qsig};
		omega_d = held_bottom_q;
		thin_d  = 1'b0;
		if (k_q == '0) begin
			omega_d = held_bottom_q;
		end else if (hsum_q == '0) begin
			thin_d = 1'b1;
		end else if (diff[FixW+3:FixW-1] == '0 || diff[FixW+3:FixW-1] == '1) begin
			omega_d = diff[FixW-1:0];
		end else begin
			omega_d = diff[FixW+3] ? {1'b1, {(FixW-1){1'b0}}} : {1'b0, {(FixW-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_count_q   <= LevelCountReset;
			level_counter_q <= '0;
			prev_div_q      <= '0;
			prev_depth_q    <= '0;
			integral_q      <= '0;
			held_bottom_q   <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) level_count_q <= cfg_wr_data;
			if (cmd.load) begin
				prev_div_q      <= div_sample;
				prev_depth_q    <= depth_sample;
				level_counter_q <= level_end ? '0 : level_counter_q + LvlW'(1);
				if (level_counter_q == '0) begin
					held_bottom_q <= bed_omega;
					integral_q    <= '0;
				end
			end
			if (cmd.acc) integral_q <= integral_q + {product_q[ProdW-1], product_q};
			if (cmd.fin) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dsum_q    <= {prev_div_q[FixW-1], prev_div_q} + {div_sample[FixW-1], div_sample};
			hsum_q    <= {1'b0, prev_depth_q} + {1'b0, depth_sample};
			spacing_q <= (level_counter_q == '0) ? '0 : node_spacing(n_eff, level_counter_q);
			k_q       <= level_counter_q;
			end_q     <= level_end;
		end
		if (cmd.mul) product_q <= dsum_q * $signed({1'b0, spacing_q});
		if (cmd.prep) begin
			neg_q    <= integral_q[IntW-1];
			big_q    <= big;
			rem_q    <= {15'd0, mag[MagW-1:SumW]};
			mag_lo_q <= mag[SumW-1:0];
			quo_q    <= '0;
		end
		if (cmd.div) begin
			rem_q    <= fits ? trial[SumW-1:0] - hsum_q : trial[SumW-1:0];
			mag_lo_q <= {mag_lo_q[SumW-2:0], 1'b0};
			quo_q    <= {quo_q[SumW-2:0], fits};
		end
		if (cmd.fin) begin
			omega       <= omega_d;
			level_index <= k_q;
			column_end  <= end_q;
			thin_layer  <= thin_d;
		end
	end

	assign sts.skip_div = (k_q == '0) || (hsum_q == '0);
	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;

endmodule

`default_nettype wire

/* hdl/column_omega_integrator.sv */
// Column omega integrator: one water-column level per input transfer, bottom
// level first, one result transfer per level.
// Channels: in_ch carries div_sample, depth_sample and bed_omega (read on
// the bottom level only); out_ch carries omega, level_index, column_end and
// thin_layer. Both use valid/ready; a transfer happens when both are high.
// level_count is written through cfg_wr_en/cfg_wr_data; the user must do so
// only while the block idles, and the block itself does not enforce this.
// Sequence: a level that needs a division goes through multiply, accumulate,
// prepare, the 33-step restoring divider (one quotient bit a cycle) and
// result load, then back to idle, where the next level is taken. A bottom
// level or a zero depth sum skips the divider and its preparation.
// Reset (arst_n low) clears the column state, sets level_count to 3 and
// empties the result register.
// Stall: the result register holds its result while out_ch.ready is low;
// the next level may still be taken and worked on, and waits at its end
// until the register is free.
`default_nettype none

module column_omega_integrator import coi_pkg::*; #(
	parameter int MAX_LEVELS = MaxLevelsDefault
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_wr_en,
	input  wire logic [CntW-1:0] cfg_wr_data,
	coi_in_if.sink               in_ch,
	coi_out_if.source            out_ch
);

	coi_cmd_t cmd;
	coi_sts_t sts;

	// sequencer: owns the input handshake and the step count of the divider
	coi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: column state, term, divider and the result register
	coi_dp #(
		.MAX_LEVELS (MAX_LEVELS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.div_sample   (in_ch.div_sample),
		.depth_sample (in_ch.depth_sample),
		.bed_omega    (in_ch.bed_omega),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_ch.valid),
		.out_ready    (out_ch.ready),
		.omega        (out_ch.omega),
		.level_index  (out_ch.level_index),
		.column_end   (out_ch.column_end),
		.thin_layer   (out_ch.thin_layer)
	);

endmodule

`default_nettype wire

/* hdl/coi_checker.sv */
// Port-level checks for the column omega integrator, bound to the top level.
// Depends on coi_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module coi_checker import coi_pkg::*; (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            in_valid,
	input wire logic            in_ready,
	input wire logic            out_valid,
	input wire logic            out_ready,
	input wire logic [LvlW-1:0] level_index,
	input wire logic            column_end,
	input wire logic            thin_layer
);

	// a pending result stays offered
	`COI_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
	// one level at a time: busy straight after an input transfer
	`COI_ASSERT_NXT(a_busy_after_in, in_valid && in_ready, !in_ready)
	// the last possible level always closes the column
	`COI_ASSERT_IMP(a_last_level_end, out_valid && (&level_index), column_end)
	// the bottom level never reports a thin layer
	`COI_ASSERT_IMP(a_thin_not_bottom, out_valid && thin_layer, level_index != '0)

endmodule

bind column_omega_integrator coi_checker u_coi_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.level_index (out_ch.level_index),
	.column_end  (out_ch.column_end),
	.thin_layer  (out_ch.thin_layer)
);

`default_nettype wire

/* bench/column_omega_integrator_tb.sv */
// Testbench for column_omega_integrator: drives water-column levels in, checks every
// omega result against a bit-true predictor held in a small scoreboard class.
// Depends on coi_pkg, coi_in_if/coi_out_if and the block itself.
`default_nettype none

module column_omega_integrator_tb import coi_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// Cycles without any transfer or register write before the run is declared hung.
	// The slowest level adds the longest sender gap and receiver stall to its own processing.
	localparam int QuietLimit = 2000;
	localparam int RandomLevels = 800;

	// One expected result transfer
	typedef struct packed {
		logic signed [FixW-1:0] omega;
		logic [LvlW-1:0]        lvl;
		logic                   col_end;
		logic                   thin;
	} omega_res_t;

	// Keeps its own copy of the column state and the level count register, works out
	// the omega for every level accepted and checks results in order against it.
	class omega_tracker;
		logic [CntW-1:0] levels_reg;
		int unsigned     next_level;
		longint          prev_div;
		longint unsigned prev_depth;
		longint          integral;      // Q.32 fraction, as the running sum is held
		longint          held_bottom;
		omega_res_t      due[$];
		int              misses;

		function new();
			levels_reg  = LevelCountReset;
			next_level  = 0;
			prev_div    = 0;
			prev_depth  = 0;
			integral    = 0;
			held_bottom = 0;
			misses      = 0;
		endfunction

		// Q0.16 node spacing of segment k-1..k in an n-level column
		function int unsigned seg_spacing(int unsigned n, int unsigned k);
			if (n < 2)
				return 0;
			if (k < 1)
				k = 1;
			if (k > n - 1)
				k = n - 1;
			case (n)
				2: return 65536;
				3: return 32768;
				4: return (k == 2) ? 29308 : 18114;
				5: return (k inside {1, 4}) ? 11316 : 21452;
				default: return (65536 + (n - 1) / 2) / (n - 1);
			endcase
		endfunction

		function void take_level(logic signed [FixW-1:0] div_s, logic [FixW-1:0] depth_s,
				logic signed [FixW-1:0] bot_s);
			int unsigned     n;
			int unsigned     k;
			bit              top;
			longint          q;
			longint          om;
			longint unsigned hsum;
			longint unsigned mag;
			omega_res_t      r;
			n = levels_reg;
			if (n < 1)
				n = 1;
			if (n > MaxLevelsDefault)
				n = MaxLevelsDefault;
			k      = next_level;
			top    = (k + 1 >= n);
			r.thin = 1'b0;
			if (k == 0) begin
				held_bottom = bot_s;
				integral    = 0;
				om          = bot_s;
			end else begin
				integral += (prev_div + longint'(div_s)) * longint'(seg_spacing(n, k));
				hsum = prev_depth + depth_s;
				if (hsum == 0) begin
					om     = held_bottom;
					r.thin = 1'b1;
				end else begin
					mag = (integral < 0) ? -integral : integral;
					q   = mag / hsum;
					if (integral < 0)
						q = -q;
					om = held_bottom - q;
					if (om > 64'sd2147483647)
						om = 64'sd2147483647;
					if (om < -64'sd2147483648)
						om = -64'sd2147483648;
				end
			end
			prev_div   = div_s;
			prev_depth = depth_s;
			next_level = top ? 0 : k + 1;
			r.omega    = om[FixW-1:0];
			r.lvl      = k[LvlW-1:0];
			r.col_end  = top;
			due.push_back(r);
		endfunction

		function void check_omega(logic signed [FixW-1:0] omega, logic [LvlW-1:0] lvl,
				logic col_end, logic thin);
			omega_res_t want;
			if (due.size() == 0) begin
				misses++;
				if (misses <= 10)
					$display("unexpected result: omega %h level %0d end %b thin %b",
						omega, lvl, col_end, thin);
				return;
			end
			want = due.pop_front();
			if (omega !== want.omega || lvl !== want.lvl || col_end !== want.col_end ||
					thin !== want.thin) begin
				misses++;
				if (misses <= 10)
					$display("mismatch: exp omega %h lvl %0d end %b thin %b, got %h %0d %b %b",
						want.omega, want.lvl, want.col_end, want.thin,
						omega, lvl, col_end, thin);
			end
		endfunction
	endclass

	logic            clk = 1'b0;
	logic            arst_n;
	logic            cfg_wr_en;
	logic [CntW-1:0] cfg_wr_data;
	bit              gaps_on = 1'b1;   // random idling on both channels
	int              quiet_cycles = 0;
	omega_tracker    sb = new();

	coi_in_if  in_ch();
	coi_out_if out_ch();

	column_omega_integrator dut (
		.clk,
		.arst_n,
		.cfg_wr_en,
		.cfg_wr_data,
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #1ns clk = ~clk;

	// Divergence and bed omega: extremes, full-range noise, mostly modest values
	function automatic logic [FixW-1:0] pick_div();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3, 4: return $urandom;
			default: return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
		endcase
	endfunction

	// Depth: zero now and then (thin layers), tiny depths (saturation), all ones, full-range noise, else 1 m..1 km
	function automatic logic [FixW-1:0] pick_depth();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(1, 255);
			3: return $urandom;
			default: return $urandom_range(32'h0001_0000, 32'h0400_0000);
		endcase
	endfunction

	// One level in: optional gap, then hold valid until the transfer.
	// valid is left high afterwards; the caller's next step decides whether it drops.
	task automatic send_level(input logic signed [FixW-1:0] div_s,
			input logic [FixW-1:0] depth_s, input logic signed [FixW-1:0] bot_s);
		int unsigned gap;
		gap = gaps_on ? $urandom_range(0, 9) : 0;
		repeat (gap) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.div_sample   <= div_s;
		in_ch.depth_sample <= depth_s;
		in_ch.bed_omega    <= bot_s;
		do begin
			@(posedge clk);
		end while (!in_ch.ready);
		sb.take_level(div_s, depth_s, bot_s);
	endtask

	// New level count, written only once every pending result has come out
	task automatic set_levels(input logic [CntW-1:0] v);
		in_ch.valid <= 1'b0;
		while (sb.due.size() != 0)
			@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en     <= 1'b0;
		sb.levels_reg = v;
	endtask

	// Result side: random stall before each transfer, check on the transfer edge
	initial begin
		int unsigned stall;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = gaps_on ? $urandom_range(0, 9) : 0;
			repeat (stall) begin
				out_ch.ready <= 1'b0;
				@(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do begin
				@(posedge clk);
			end while (!out_ch.valid);
			sb.check_omega(out_ch.omega, out_ch.level_index, out_ch.column_end,
				out_ch.thin_layer);
		end
	end

	// Hang detection: any transfer or register write restarts the count
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				cfg_wr_en) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QuietLimit) begin
			$display("column_omega_integrator_tb NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int unsigned sent;
		int unsigned phase_len;
		int unsigned count_sel;
		bit          dry;
		arst_n             = 1'b0;
		cfg_wr_en          = 1'b0;
		cfg_wr_data        = '0;
		in_ch.valid        = 1'b0;
		in_ch.div_sample   = '0;
		in_ch.depth_sample = '0;
		in_ch.bed_omega    = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset count of 3: field extremes, last level with a zero depth
		send_level(32'sh7FFF_FFFF, 32'hFFFF_FFFF, 32'sh7FFF_FFFF);
		send_level(32'sh8000_0000, 32'hFFFF_FFFF, 32'sh0000_0000);
		send_level(32'sh8000_0000, 32'h0000_0000, 32'sh8000_0000);

		// Two levels: huge integral over a tiny depth saturates upwards, then downwards,
		// then both depths zero gives a thin layer
		set_levels(4'd2);
		send_level(32'sh8000_0000, 32'h0000_0000, 32'sh7FFF_FFFF);
		send_level(32'sh8000_0000, 32'h0000_0001, 32'sh0000_1234);
		send_level(32'sh7FFF_FFFF, 32'h0000_0000, 32'sh8000_0000);
		send_level(32'sh7FFF_FFFF, 32'h0000_0001, 32'sh0000_0000);
		send_level(32'sh0001_0000, 32'h0000_0000, 32'sh0000_3039);
		send_level(32'shFFFF_0000, 32'h0000_0000, 32'sh7FFF_0000);

		// Single-level columns, and a count of zero which behaves as one
		set_levels(4'd1);
		send_level(32'sh0000_8000, 32'h0010_0000, 32'shFFFF_FFFF);
		send_level(32'shFFFF_8000, 32'h0020_0000, 32'sh0000_0001);
		set_levels(4'd0);
		send_level(32'sh1234_5678, 32'h8000_0000, 32'sh8765_4321);
		send_level(32'shEDCB_A988, 32'h7FFF_FFFF, 32'sh7FFF_FFFF);

		// Count above the maximum acts as eight; cut short by a smaller count mid column,
		// so the next level is forced to be the top one with the last segment's spacing
		set_levels(4'd15);
		send_level(32'sh0002_0000, 32'h0100_0000, 32'sh0000_4000);
		send_level(32'sh0003_0000, 32'h0110_0000, 32'sh0000_0000);
		send_level(32'shFFFC_0000, 32'h0120_0000, 32'sh0000_0000);
		set_levels(4'd2);
		send_level(32'sh0005_0000, 32'h0130_0000, 32'sh0000_0000);

		// Four levels: both Lobatto spacings
		set_levels(4'd4);
		send_level(32'sh0001_8000, 32'h00A0_0000, 32'shFFFF_C000);
		send_level(32'shFFFE_0000, 32'h00A8_0000, 32'sh0000_0000);
		send_level(32'sh0004_4000, 32'h00B0_0000, 32'sh0000_0000);
		send_level(32'sh0000_1000, 32'h00B8_0000, 32'sh0000_0000);

		// Mid-column drop to a single level: that level ends the column with no spacing
		set_levels(4'd3);
		send_level(32'sh0006_0000, 32'h0050_0000, 32'sh0000_2000);
		set_levels(4'd1);
		send_level(32'sh0007_0000, 32'h0060_0000, 32'sh0000_0000);
		send_level(32'sh0008_0000, 32'h0070_0000, 32'sh0000_0000);

		// Random phases: mostly legal counts, whole columns with some cut short,
		// now and then a dry stretch and a phase with no idling at all
		sent = 0;
		while (sent < RandomLevels) begin
			if ($urandom_range(0, 3) == 0)
				count_sel = $urandom_range(0, 15);
			else
				count_sel = $urandom_range(1, 8);
			set_levels(count_sel[CntW-1:0]);
			gaps_on   = ($urandom_range(0, 3) != 0);
			dry       = ($urandom_range(0, 9) == 0);
			phase_len = $urandom_range(1, 40);
			repeat (phase_len) begin
				send_level(pick_div(), dry ? '0 : pick_depth(), pick_div());
				sent++;
			end
		end

		in_ch.valid <= 1'b0;
		while (sb.due.size() != 0)
			@(posedge clk);
		// room for any stray result transfer to show up
		repeat (60) @(posedge clk);
		if (sb.misses == 0 && sb.due.size() == 0)
			$display("column_omega_integrator_tb OK");
		else
			$display("column_omega_integrator_tb NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
